// ===== hw/rtl/object_merge_table_top_macros.svh =====
// assertion macros for the object merge table
// used by the sequencer; clock clk_i and reset rst_ni must be in scope
`ifndef OBJECT_MERGE_TABLE_TOP_MACROS_SVH
`define OBJECT_MERGE_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// check outside reset
`define OMT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define OMT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define OMT_ASSERT(name, prop, msg)
`define OMT_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== hw/rtl/omt_pkg.sv =====
// shared types, codes and constants of the object merge table
// no dependencies; imported by every rtl module of the block
package omt_pkg;

  localparam int unsigned TableDepthDefault = 16;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned RptW     = 5;
  localparam int unsigned SqW      = 2 * CoordW;
  localparam int unsigned SumW     = SqW + 1;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  // object kinds
  localparam logic [KindW-1:0] KIND_PLAIN     = 2'd0;
  localparam logic [KindW-1:0] KIND_BARREL    = 2'd1;
  localparam logic [KindW-1:0] KIND_CONTAINER = 2'd2;

  // register indexes (word address)
  localparam logic [RegIdxW-1:0] REG_MERGE_DIST = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CONT_MAX   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CONT_MIN   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_BARREL_MAX = 3'd3;
  localparam logic [RegIdxW-1:0] REG_BARREL_MIN = 3'd4;

  // register reset values
  localparam logic [SizeW-1:0] MERGE_DIST_RST = 16'd64;
  localparam logic [SizeW-1:0] CONT_MAX_RST   = 16'd282;
  localparam logic [SizeW-1:0] CONT_MIN_RST   = 16'd20;
  localparam logic [SizeW-1:0] BARREL_MAX_RST = 16'd154;
  localparam logic [SizeW-1:0] BARREL_MIN_RST = 16'd20;

  typedef enum logic [1:0] {
    ST_REJECTED = 2'd0,
    ST_MERGED   = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_LIM,
    S_RD,
    S_SQX,
    S_SQY,
    S_CMP,
    S_END
  } omt_state_e;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic [SizeW-1:0]         radius;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
  } obj_req_t;

  typedef struct packed {
    status_e          status;
    logic [RptW-1:0]  merge_count;
    logic [RptW-1:0]  entry_count;
  } obj_rsp_t;

  typedef struct packed {
    logic [SizeW-1:0] merge_distance;
    logic [SizeW-1:0] container_side_max;
    logic [SizeW-1:0] container_side_min;
    logic [SizeW-1:0] barrel_radius_max;
    logic [SizeW-1:0] barrel_radius_min;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [KindW-1:0]         kind;
  } entry_t;

  // controls of the shared squaring unit
  typedef struct packed {
    logic prod_en;
    logic acc_load;
  } sq_ctrl_t;

  // floor of the mean of two signed coordinates
  function automatic logic signed [CoordW-1:0] floor_avg(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    logic [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

endpackage

// ===== hw/rtl/object_merge_table_top.sv =====
// object merge table: each request passes the size filter, then a walk over the stored entries
// (skipped when rejected by size or when the table is empty), then the result register.
// a new request is taken only back in idle, once its result is loaded; the shared squaring unit
// spends four steps (read, x square, y square, compare and write-back) on each entry.
// reset (asynchronous, active low) empties the table and restores the register defaults;
// table contents are not cleared, entries beyond the count are never read.
module object_merge_table_top import omt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  obj_req_t            in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obj_rsp_t            out_rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_wr;
  logic [SizeW-1:0]   rd_val;

  logic            ram_wr_en;
  logic [IdxW-1:0] ram_wr_addr;
  entry_t          ram_wr_data;
  logic            ram_rd_en;
  logic [IdxW-1:0] ram_rd_addr;
  entry_t          ram_rd_data;

  sq_ctrl_t          sq_ctrl;
  logic [CoordW-1:0] sq_op;
  logic [SqW-1:0]    sq_prod;
  logic [SumW-1:0]   sq_sum;

  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_distance     <= MERGE_DIST_RST;
      cfg_q.container_side_max <= CONT_MAX_RST;
      cfg_q.container_side_min <= CONT_MIN_RST;
      cfg_q.barrel_radius_max  <= BARREL_MAX_RST;
      cfg_q.barrel_radius_min  <= BARREL_MIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MERGE_DIST: cfg_q.merge_distance     <= pwdata[SizeW-1:0];
        REG_CONT_MAX:   cfg_q.container_side_max <= pwdata[SizeW-1:0];
        REG_CONT_MIN:   cfg_q.container_side_min <= pwdata[SizeW-1:0];
        REG_BARREL_MAX: cfg_q.barrel_radius_max  <= pwdata[SizeW-1:0];
        REG_BARREL_MIN: cfg_q.barrel_radius_min  <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      REG_MERGE_DIST: rd_val = cfg_q.merge_distance;
      REG_CONT_MAX:   rd_val = cfg_q.container_side_max;
      REG_CONT_MIN:   rd_val = cfg_q.container_side_min;
      REG_BARREL_MAX: rd_val = cfg_q.barrel_radius_max;
      REG_BARREL_MIN: rd_val = cfg_q.barrel_radius_min;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = CfgDataW'(rd_val);

  // sequencer
  omt_ctrl #(
    .TableDepth(TableDepth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_i      (in_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_o     (out_rsp_o),
    .cfg_i         (cfg_q),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .sq_ctrl_o     (sq_ctrl),
    .sq_op_o       (sq_op),
    .sq_prod_i     (sq_prod),
    .sq_sum_i      (sq_sum)
  );

  // stored objects
  omt_entry_ram #(
    .Depth(TableDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // shared squaring unit
  omt_sq_unit u_sq (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .op_i   (sq_op),
    .prod_o (sq_prod),
    .sum_o  (sq_sum)
  );

endmodule

// ===== hw/rtl/omt_entry_ram.sv =====
// single write port, single registered read port table of stored objects
// depends on omt_pkg for the entry type
module omt_entry_ram import omt_pkg::*; #(
  parameter int unsigned Depth = TableDepthDefault,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  entry_t          wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output entry_t          rd_data_o
);

  entry_t mem [Depth];
  entry_t rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/omt_sq_unit.sv =====
// shared squaring unit: one 16x16 multiplier with a product and an accumulator register
// depends on omt_pkg for widths and the control struct
module omt_sq_unit import omt_pkg::*; (
  input  logic              clk_i,
  input  sq_ctrl_t          ctrl_i,
  input  logic [CoordW-1:0] op_i,
  output logic [SqW-1:0]    prod_o,
  output logic [SumW-1:0]   sum_o
);

  logic [SqW-1:0] prod_q;
  logic [SqW-1:0] acc_q;

  // square the operand, then hold the first square for the sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      prod_q <= SqW'(op_i) * SqW'(op_i);
    end
    if (ctrl_i.acc_load) begin
      acc_q <= prod_q;
    end
  end

  assign prod_o = prod_q;
  assign sum_o  = SumW'(acc_q) + SumW'(prod_q);

endmodule

// ===== hw/rtl/omt_ctrl.sv =====
// sequencer: size filter, walk over stored entries, merge write-back, append, result register
// depends on omt_pkg and the assertion macros; drives the entry ram and the squaring unit
`include "object_merge_table_top_macros.svh"

module omt_ctrl import omt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  localparam int unsigned CntW = $clog2(TableDepth + 1),
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  obj_req_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output obj_rsp_t          out_rsp_o,
  input  cfg_t              cfg_i,
  output logic              ram_wr_en_o,
  output logic [IdxW-1:0]   ram_wr_addr_o,
  output entry_t            ram_wr_data_o,
  output logic              ram_rd_en_o,
  output logic [IdxW-1:0]   ram_rd_addr_o,
  input  entry_t            ram_rd_data_i,
  output sq_ctrl_t          sq_ctrl_o,
  output logic [CoordW-1:0] sq_op_o,
  input  logic [SqW-1:0]    sq_prod_i,
  input  logic [SumW-1:0]   sq_sum_i
);

  omt_state_e      state_q, state_d;
  obj_req_t        item_q;
  logic            reject_q;
  logic [SqW-1:0]  lim_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] merges_q;
  logic            out_valid_q;
  obj_rsp_t        out_q;

  logic              reject;
  logic              skip;
  logic              hit;
  logic              is_last;
  logic              full;
  logic              out_free;
  logic              append;
  logic              rsp_load;
  status_e           status;
  logic [CntW-1:0]   cnt_d;
  logic [CoordW:0]   dx;
  logic [CoordW:0]   dy;
  logic [CoordW-1:0] ax;
  logic [CoordW-1:0] ay;

  // size filter by kind
  always_comb begin
    unique case (item_q.kind)
      KIND_CONTAINER: reject = (item_q.width  > cfg_i.container_side_max) ||
                               (item_q.height > cfg_i.container_side_max) ||
                               (item_q.width  < cfg_i.container_side_min) ||
                               (item_q.height < cfg_i.container_side_min);
      KIND_BARREL:    reject = (item_q.radius > cfg_i.barrel_radius_max) ||
                               (item_q.radius < cfg_i.barrel_radius_min);
      default:        reject = 1'b0;
    endcase
  end

  // per-axis distance magnitudes against the entry just read
  assign dx = {item_q.centre_x[CoordW-1], item_q.centre_x} -
              {ram_rd_data_i.x[CoordW-1], ram_rd_data_i.x};
  assign dy = {item_q.centre_y[CoordW-1], item_q.centre_y} -
              {ram_rd_data_i.y[CoordW-1], ram_rd_data_i.y};
  assign ax = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
  assign ay = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];

  // same centre but other kind never merges
  assign skip = (ram_rd_data_i.x == item_q.centre_x) &&
                (ram_rd_data_i.y == item_q.centre_y) &&
                (ram_rd_data_i.kind != item_q.kind);
  assign hit  = !skip && (sq_sum_i < {1'b0, lim_q});

  assign is_last  = (idx_q + CntW'(1)) == cnt_q;
  assign full     = cnt_q == CntW'(TableDepth);
  assign out_free = !out_valid_q || !out_stall_i;
  assign append   = !reject_q && (merges_q == '0) && !full;
  assign rsp_load = (state_q == S_END) && out_free;
  assign cnt_d    = append ? cnt_q + CntW'(1) : cnt_q;

  // result code
  always_comb begin
    priority if (reject_q) begin
      status = ST_REJECTED;
    end else if (merges_q != '0) begin
      status = ST_MERGED;
    end else if (!full) begin
      status = ST_INSERTED;
    end else begin
      status = ST_FULL;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_FILT;
      S_FILT: state_d = reject ? S_END : S_LIM;
      S_LIM:  state_d = (cnt_q == '0) ? S_END : S_RD;
      S_RD:   state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_CMP;
      S_CMP:  state_d = is_last ? S_END : S_RD;
      S_END:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs towards the ram and the squaring unit
  always_comb begin
    in_stall_o         = state_q != S_IDLE;
    ram_rd_en_o        = state_q == S_RD;
    ram_rd_addr_o      = idx_q[IdxW-1:0];
    ram_wr_en_o        = 1'b0;
    ram_wr_addr_o      = idx_q[IdxW-1:0];
    ram_wr_data_o.x    = floor_avg(item_q.centre_x, ram_rd_data_i.x);
    ram_wr_data_o.y    = floor_avg(item_q.centre_y, ram_rd_data_i.y);
    ram_wr_data_o.kind = ram_rd_data_i.kind;
    sq_ctrl_o.prod_en  = 1'b0;
    sq_ctrl_o.acc_load = 1'b0;
    sq_op_o            = cfg_i.merge_distance;
    unique case (state_q)
      S_FILT: begin
        sq_ctrl_o.prod_en = 1'b1;
      end
      S_SQX: begin
        sq_ctrl_o.prod_en = 1'b1;
        sq_op_o           = ax;
      end
      S_SQY: begin
        sq_ctrl_o.prod_en  = 1'b1;
        sq_ctrl_o.acc_load = 1'b1;
        sq_op_o            = ay;
      end
      S_CMP: begin
        ram_wr_en_o = hit;
      end
      S_END: begin
        ram_wr_en_o        = out_free && append;
        ram_wr_addr_o      = cnt_q[IdxW-1:0];
        ram_wr_data_o.x    = item_q.centre_x;
        ram_wr_data_o.y    = item_q.centre_y;
        ram_wr_data_o.kind = item_q.kind;
      end
      default: ;
    endcase
  end

  // state, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      merges_q    <= '0;
      reject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FILT) begin
        reject_q <= reject;
        merges_q <= '0;
        idx_q    <= '0;
      end
      if (state_q == S_CMP) begin
        idx_q <= idx_q + CntW'(1);
        if (hit) merges_q <= merges_q + CntW'(1);
      end
      if (rsp_load) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, threshold and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_req_i;
    end
    if (state_q == S_LIM) begin
      lim_q <= sq_prod_i;
    end
    if (rsp_load) begin
      out_q.status      <= status;
      out_q.merge_count <= RptW'(merges_q);
      out_q.entry_count <= RptW'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `OMT_ASSERT(a_cnt_bound, cnt_q <= CntW'(TableDepth), "entry count above depth")
  `OMT_ASSERT(a_cnt_step, (cnt_q - $past(cnt_q)) <= CntW'(1), "entry count jumped")
  `OMT_ASSERT(a_rd_range, (state_q == S_RD) |-> (idx_q < cnt_q), "read beyond valid entries")
  `OMT_ASSERT(a_merge_code, rsp_load |-> ((status == ST_MERGED) == (merges_q != '0)), "merge code mismatch")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench for object_merge_table_top: directed and random object requests, checked
// result by result against a behavioural merge table; depends on omt_pkg and the rtl
module tb;
  import omt_pkg::*;

  localparam int unsigned DEPTH = TableDepthDefault;
  // kind code with no filter of its own, stored as a kind apart from plain
  localparam logic [KindW-1:0] KIND_OTHER = 2'd3;
  // drain wait: room for a request that walks every entry, plus margin
  localparam int DRAIN_CYCLES = 3 + 4 * DEPTH + 16;
  localparam int HOLD_OFF_CYCLES = 400;
  // receiver hold-off plus the longest gap, stall and latency, taken several times over
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  obj_req_t            in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  obj_rsp_t            out_rsp_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // behavioural copy of the table and the registers
  logic signed [CoordW-1:0] tbl_x [DEPTH];
  logic signed [CoordW-1:0] tbl_y [DEPTH];
  logic [KindW-1:0]         tbl_kind [DEPTH];
  int                       tbl_count;
  logic [SizeW-1:0]         merge_dist;
  logic [SizeW-1:0]         cont_max;
  logic [SizeW-1:0]         cont_min;
  logic [SizeW-1:0]         barrel_max;
  logic [SizeW-1:0]         barrel_min;

  obj_rsp_t pending_rsp_q [$];
  int       errors;
  int       n_reqs;
  int       n_settings;
  int       n_status [4];
  int       quiet_cycles;
  bit       idling;
  bit       hold_off_req;
  int       stall_left;

  object_merge_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // expected result of one request; updates the table copy as the block would
  function automatic obj_rsp_t predict_merge(input obj_req_t r);
    obj_rsp_t rsp;
    logic     rej;
    longint   cx, cy, ex, ey, dx, dy, lim;
    int       merges;
    rej = 1'b0;
    merges = 0;
    if (r.kind == KIND_CONTAINER) begin
      rej = r.width > cont_max || r.height > cont_max ||
            r.width < cont_min || r.height < cont_min;
    end else if (r.kind == KIND_BARREL) begin
      rej = r.radius > barrel_max || r.radius < barrel_min;
    end
    if (rej) begin
      rsp.status = ST_REJECTED;
    end else begin
      cx = $signed(r.centre_x);
      cy = $signed(r.centre_y);
      lim = longint'(merge_dist) * longint'(merge_dist);
      for (int i = 0; i < tbl_count; i++) begin
        ex = tbl_x[i];
        ey = tbl_y[i];
        // same centre but another kind: left alone
        if (ex == cx && ey == cy && tbl_kind[i] != r.kind) continue;
        dx = cx - ex;
        dy = cy - ey;
        if (dx * dx + dy * dy < lim) begin
          tbl_x[i] = CoordW'((cx + ex) >>> 1);
          tbl_y[i] = CoordW'((cy + ey) >>> 1);
          merges++;
        end
      end
      if (merges > 0) begin
        rsp.status = ST_MERGED;
      end else if (tbl_count < DEPTH) begin
        tbl_x[tbl_count] = r.centre_x;
        tbl_y[tbl_count] = r.centre_y;
        tbl_kind[tbl_count] = r.kind;
        tbl_count++;
        rsp.status = ST_INSERTED;
      end else begin
        rsp.status = ST_FULL;
      end
    end
    rsp.merge_count = RptW'(merges);
    rsp.entry_count = RptW'(tbl_count);
    return rsp;
  endfunction

  function automatic void check_field(input string what, input logic [4:0] want,
                                      input logic [4:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // result checker, then request capture; a result always belongs to an older request
  always @(posedge clk_i) begin
    obj_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d merges %0d count %0d",
                   $time, out_rsp_o.status, out_rsp_o.merge_count, out_rsp_o.entry_count);
          errors++;
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("status", 5'(want.status), 5'(out_rsp_o.status));
          check_field("merge_count", want.merge_count, out_rsp_o.merge_count);
          check_field("entry_count", want.entry_count, out_rsp_o.entry_count);
          n_status[want.status]++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_rsp_q = {pending_rsp_q, predict_merge(in_req_i)};
        n_reqs++;
      end
    end
  end

  // watchdog on cycles without any request or result handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int p;
    if (!idling) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (idling && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // offer one request after a gap; valid stays high after acceptance
  task automatic send_obj(input obj_req_t r, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and let every request come back
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, or read compared with the expected value
  task automatic reg_access(input bit wr, input logic [RegIdxW-1:0] idx,
                            input logic [SizeW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= CfgDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== CfgDataW'(val)) begin
      $display("%0t: register %0d read mismatch: expected %0d, got %0d",
               $time, idx, val, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (wr) begin
      case (idx)
        REG_MERGE_DIST: merge_dist = val;
        REG_CONT_MAX:   cont_max = val;
        REG_CONT_MIN:   cont_min = val;
        REG_BARREL_MAX: barrel_max = val;
        REG_BARREL_MIN: barrel_min = val;
        default: ;
      endcase
    end
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [SizeW-1:0] md, input logic [SizeW-1:0] cmax,
                            input logic [SizeW-1:0] cmin, input logic [SizeW-1:0] bmax,
                            input logic [SizeW-1:0] bmin);
    drain_block();
    reg_access(1'b1, REG_MERGE_DIST, md);
    reg_access(1'b1, REG_CONT_MAX, cmax);
    reg_access(1'b1, REG_CONT_MIN, cmin);
    reg_access(1'b1, REG_BARREL_MAX, bmax);
    reg_access(1'b1, REG_BARREL_MIN, bmin);
    n_settings++;
  endtask

  function automatic obj_req_t obj(input logic [KindW-1:0] k, input int x, input int y,
                                   input logic [SizeW-1:0] rad, input logic [SizeW-1:0] w,
                                   input logic [SizeW-1:0] h);
    obj_req_t r;
    r.kind = k;
    r.centre_x = CoordW'(x);
    r.centre_y = CoordW'(y);
    r.radius = rad;
    r.width = w;
    r.height = h;
    return r;
  endfunction

  // size near the configured limits most of the time, anything otherwise
  function automatic logic [SizeW-1:0] pick_size(input logic [SizeW-1:0] lo,
                                                 input logic [SizeW-1:0] hi);
    int a, b;
    if ($urandom_range(0, 3) == 0) return SizeW'($urandom);
    a = (lo < hi) ? int'(lo) : int'(hi);
    b = (lo < hi) ? int'(hi) : int'(lo);
    a = (a < 2) ? 0 : a - 2;
    b = (b > 65533) ? 65535 : b + 2;
    return SizeW'($urandom_range(a, b));
  endfunction

  // mostly objects around stored centres, some on them exactly, the rest anywhere
  function automatic obj_req_t make_random_obj();
    obj_req_t r;
    int       sel, idx, span;
    r.kind = ($urandom_range(0, 9) == 0) ? KIND_OTHER : KindW'($urandom_range(0, 2));
    r.centre_x = CoordW'($urandom);
    r.centre_y = CoordW'($urandom);
    sel = $urandom_range(0, 99);
    if (tbl_count > 0 && sel < 70) begin
      idx = $urandom_range(0, tbl_count - 1);
      if (sel < 12) begin
        r.centre_x = tbl_x[idx];
        r.centre_y = tbl_y[idx];
      end else begin
        span = int'(merge_dist) + int'(merge_dist) / 2 + 2;
        if (span > 20000) span = 20000;
        r.centre_x = tbl_x[idx] + CoordW'(int'($urandom_range(0, 2 * span)) - span);
        r.centre_y = tbl_y[idx] + CoordW'(int'($urandom_range(0, 2 * span)) - span);
      end
    end
    r.radius = pick_size(barrel_min, barrel_max);
    r.width = pick_size(cont_min, cont_max);
    r.height = pick_size(cont_min, cont_max);
    return r;
  endfunction

  task automatic run_random_phase(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      // every fourth stretch runs with no gaps and no stalls
      idling = ((i / 48) % 4) != 3;
      send_obj(make_random_obj(), pick_gap());
    end
  endtask

  // limits, kinds, skipping, exact threshold and table overflow at reset settings
  task automatic test_directed_cases();
    idling = 1'b1;
    // around the origin: insert, skip on kind, merge, threshold
    send_obj(obj(KIND_PLAIN, 0, 0, 0, 0, 0), 0);
    send_obj(obj(KIND_BARREL, 0, 0, 100, 0, 0), 1);
    send_obj(obj(KIND_OTHER, 0, 0, 16'hffff, 16'hffff, 16'hffff), 0);
    send_obj(obj(KIND_PLAIN, 0, 0, 0, 0, 0), 2);
    send_obj(obj(KIND_PLAIN, 64, 0, 0, 0, 0), 0);
    send_obj(obj(KIND_PLAIN, 63, 0, 0, 0, 0), 0);
    // container size filter
    send_obj(obj(KIND_CONTAINER, 5000, 5000, 0, 19, 100), 0);
    send_obj(obj(KIND_CONTAINER, 5000, 5000, 0, 100, 283), 3);
    send_obj(obj(KIND_CONTAINER, -32768, -32768, 16'hffff, 20, 282), 0);
    send_obj(obj(KIND_CONTAINER, 5000, 5000, 0, 16'hffff, 16'hffff), 0);
    // barrel size filter
    send_obj(obj(KIND_BARREL, 5000, 5000, 19, 0, 0), 0);
    send_obj(obj(KIND_BARREL, 5000, 5000, 155, 0, 0), 1);
    send_obj(obj(KIND_BARREL, 32767, 32767, 20, 16'hffff, 0), 0);
    send_obj(obj(KIND_BARREL, 32767, -32768, 154, 0, 16'hffff), 0);
    send_obj(obj(KIND_BARREL, 5000, 5000, 0, 0, 0), 0);
    send_obj(obj(KIND_PLAIN, -32768, 32767, 0, 0, 0), 0);
    // fill the remaining entries, then one more that has nowhere to go
    for (int k = 0; k < 8; k++) begin
      send_obj(obj(KIND_PLAIN, -24000 + 6000 * k, 12000, 0, 0, 0), k % 2);
    end
    send_obj(obj(KIND_CONTAINER, -12000, -12000, 0, 100, 100), 0);
  endtask

  // reset values, both extremes and write-back of the defaults for every register
  task automatic test_register_access();
    drain_block();
    reg_access(1'b0, REG_MERGE_DIST, MERGE_DIST_RST);
    reg_access(1'b0, REG_CONT_MAX, CONT_MAX_RST);
    reg_access(1'b0, REG_CONT_MIN, CONT_MIN_RST);
    reg_access(1'b0, REG_BARREL_MAX, BARREL_MAX_RST);
    reg_access(1'b0, REG_BARREL_MIN, BARREL_MIN_RST);
    for (int i = 0; i <= int'(REG_BARREL_MIN); i++) begin
      reg_access(1'b1, RegIdxW'(i), 16'hffff);
      reg_access(1'b0, RegIdxW'(i), 16'hffff);
      reg_access(1'b1, RegIdxW'(i), 16'h0000);
      reg_access(1'b0, RegIdxW'(i), 16'h0000);
    end
    set_config(MERGE_DIST_RST, CONT_MAX_RST, CONT_MIN_RST, BARREL_MAX_RST, BARREL_MIN_RST);
    reg_access(1'b0, REG_MERGE_DIST, MERGE_DIST_RST);
  endtask

  // random traffic under several register settings, extremes included
  task automatic test_config_sweep();
    int a, b, c, d;
    run_random_phase(250);
    // nothing merges, nothing rejected by size
    set_config(16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0);
    run_random_phase(150);
    // merge threshold at its largest, every sized object rejected
    set_config(16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff);
    run_random_phase(100);
    for (int p = 0; p < 3; p++) begin
      a = $urandom_range(0, 600);
      b = $urandom_range(0, 600);
      c = $urandom_range(0, 400);
      d = $urandom_range(0, 400);
      set_config(SizeW'($urandom_range(0, 1500)), SizeW'(a > b ? a : b),
                 SizeW'(a > b ? b : a), SizeW'(c > d ? c : d), SizeW'(c > d ? d : c));
      run_random_phase(150);
    end
    set_config(16'd1024, 16'd400, 16'd10, 16'd200, 16'd5);
    run_random_phase(200);
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    set_config(MERGE_DIST_RST, CONT_MAX_RST, CONT_MIN_RST, BARREL_MAX_RST, BARREL_MIN_RST);
    idling = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 30; i++) send_obj(make_random_obj(), 0);
    idling = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    n_reqs = 0;
    n_settings = 1;
    n_status = '{default: 0};
    quiet_cycles = 0;
    idling = 1'b1;
    hold_off_req = 1'b0;
    tbl_count = 0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_kind[i] = '0;
    end
    merge_dist = MERGE_DIST_RST;
    cont_max = CONT_MAX_RST;
    cont_min = CONT_MIN_RST;
    barrel_max = BARREL_MAX_RST;
    barrel_min = BARREL_MIN_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_register_access();
    test_config_sweep();
    test_backpressure();

    drain_block();
    $display("covered %0d requests under %0d register settings", n_reqs, n_settings);
    $display("merged %0d, inserted %0d, rejected by size %0d, dropped on full table %0d",
             n_status[ST_MERGED], n_status[ST_INSERTED], n_status[ST_REJECTED],
             n_status[ST_FULL]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/omt_pkg.sv
hw/rtl/omt_entry_ram.sv
hw/rtl/omt_sq_unit.sv
hw/rtl/omt_ctrl.sv
hw/rtl/object_merge_table_top.sv
verif/tb.sv
